@@ design/assert_macros.svh @@
// Assertion macros shared by the button classifier RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge while the block is out of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising clk edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ design/bphc_pkg.sv @@
// Shared types and constants for the button press and hold classifier.
// No dependencies; every design module imports this package.
package bphc_pkg;

  localparam int IDX_W       = 3;
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
  localparam logic [CFG_W-1:0] HOLD_RESET     = 16'd1000;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] hold_ms;
    logic [CNT_W-1:0] active_count;
  } cfg_t;

  typedef struct packed {
    logic             last_level;
    logic             ignore_release;
    logic             long_mode;
    logic [NOW_W-1:0] press_time;
    logic [NOW_W-1:0] release_time;
  } btn_state_t;

endpackage

@@ design/bphc_cfg.sv @@
// Configuration register bank of the button classifier.
// Depends on bphc_pkg for the register indexes and reset values.
module bphc_cfg
  import bphc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ms  <= DEBOUNCE_RESET;
      cfg.hold_ms      <= HOLD_RESET;
      cfg.active_count <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ms  <= cfg_data;
        REG_HOLD:     cfg.hold_ms      <= cfg_data;
        REG_ACTIVE:   cfg.active_count <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/bphc_state.sv @@
// Per-button state registers with one read port and one write port.
// Depends on bphc_pkg for the per-button state record.
module bphc_state
  import bphc_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] index,
  input  logic             wr_en,
  input  btn_state_t       wr_data,
  output btn_state_t       rd_data
);

  // Six bits cover every button number up to 63 and any 3-bit index.
  localparam int CMP_W = 6;

  btn_state_t entry [NUM_BUTTONS];
  logic [CMP_W-1:0] index_ext;

  assign index_ext = {{(CMP_W-IDX_W){1'b0}}, index};

  always_comb begin
    rd_data = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (index_ext == CMP_W'(b)) begin
        rd_data = entry[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (rst) begin
        entry[b] <= '0;
      end else if (wr_en && index_ext == CMP_W'(b)) begin
        entry[b] <= wr_data;
      end
    end
  end

endmodule

@@ design/bphc_rules.sv @@
// Combinational press, release and hold rules for one button sample.
// Depends on bphc_pkg for the configuration and state records.
module bphc_rules
  import bphc_pkg::*;
(
  input  cfg_t             cfg,
  input  btn_state_t       cur,
  input  logic             active,
  input  logic             level,
  input  logic [NOW_W-1:0] now_ms,
  output btn_state_t       nxt,
  output logic             wr_en,
  output logic             short_press,
  output logic             long_press
);

  logic [NOW_W-1:0] since_press;
  logic [NOW_W-1:0] since_release;
  logic             release_edge;
  logic             press_edge;
  logic             hold_hit;

  // Wrapping differences, as elapsed time on a free-running millisecond clock.
  assign since_press   = now_ms - cur.press_time;
  assign since_release = now_ms - cur.release_time;

  assign release_edge = level && !cur.last_level &&
                        (since_press > {{(NOW_W-CFG_W){1'b0}}, cfg.debounce_ms});
  assign press_edge   = !level && cur.last_level &&
                        (since_release > {{(NOW_W-CFG_W){1'b0}}, cfg.debounce_ms});
  // A press edge restamps the press time, so no hold can follow it in the
  // same sample; both hold rules collapse into one that toggles long mode.
  assign hold_hit     = !level && !press_edge &&
                        (since_press > {{(NOW_W-CFG_W){1'b0}}, cfg.hold_ms});

  assign wr_en       = active;
  assign short_press = active && press_edge && !cur.ignore_release;
  assign long_press  = active && release_edge && !cur.ignore_release && cur.long_mode;

  always_comb begin
    nxt            = cur;
    nxt.last_level = level;
    if (release_edge) begin
      if (cur.ignore_release || !cur.long_mode) begin
        nxt.ignore_release = 1'b0;
      end
      nxt.release_time = now_ms;
    end
    if (press_edge) begin
      if (cur.ignore_release) begin
        nxt.ignore_release = 1'b0;
      end
      nxt.press_time = now_ms;
    end
    if (hold_hit) begin
      nxt.ignore_release = 1'b1;
      nxt.press_time     = now_ms;
      nxt.long_mode      = !cur.long_mode;
    end
  end

endmodule

@@ design/button_press_hold_classifier.sv @@
// Pipeline: an accepted sample goes into the input register and then into the result
// register, from which its result transaction is offered on the result stream.
// Throughput: one sample per cycle while m_axis_tready does not stall the result register;
// the per-button state is read and written back as the sample moves to the result register.
// Reset (rst, synchronous, active high) empties both registers, clears all
// per-button state and loads debounce_ms = 50, hold_ms = 1000, active_count = 0.
// Depends on bphc_pkg, bphc_cfg, bphc_state, bphc_rules and assert_macros.svh.
`include "assert_macros.svh"

module button_press_hold_classifier
  import bphc_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // Sample stream. tdata from bit 0: button_index[2:0], level[3], now_ms[35:4],
  // zero padding[39:36].
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Result stream. tdata from bit 0: button_out[2:0], short_press[3],
  // long_press[4], zero padding[7:5].
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration writes: index 0 debounce_ms, 1 hold_ms, 2 active_count.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int CMP_W = 6;

  cfg_t       cfg;
  btn_state_t cur_state;
  btn_state_t nxt_state;

  // Input register.
  logic             in_valid;
  logic [IDX_W-1:0] in_index;
  logic             in_level;
  logic [NOW_W-1:0] in_now;

  // Result register.
  logic             out_valid;
  logic [IDX_W-1:0] out_index;
  logic             out_short;
  logic             out_long;

  logic             advance;
  logic             in_load;
  logic             active;
  logic             rule_wr;
  logic             state_wr;
  logic             short_press;
  logic             long_press;

  // The result register moves whenever it is empty or being drained, and the
  // input register may then refill in the same cycle.
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // A button takes part only below both active_count and the number of
  // buttons the state storage holds; other indexes pass through untouched.
  assign active = ({{(CMP_W-IDX_W){1'b0}}, in_index} <
                   {{(CMP_W-CNT_W){1'b0}}, cfg.active_count}) &&
                  ({{(CMP_W-IDX_W){1'b0}}, in_index} < CMP_W'(NUM_BUTTONS));

  assign state_wr = in_valid && advance && rule_wr;

  bphc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bphc_state #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_state (
    .clk     (clk),
    .rst     (rst),
    .index   (in_index),
    .wr_en   (state_wr),
    .wr_data (nxt_state),
    .rd_data (cur_state)
  );

  bphc_rules u_rules (
    .cfg         (cfg),
    .cur         (cur_state),
    .active      (active),
    .level       (in_level),
    .now_ms      (in_now),
    .nxt         (nxt_state),
    .wr_en       (rule_wr),
    .short_press (short_press),
    .long_press  (long_press)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
    if (in_load) begin
      in_index <= s_axis_tdata[IDX_W-1:0];
      in_level <= s_axis_tdata[IDX_W];
      in_now   <= s_axis_tdata[IDX_W+NOW_W:IDX_W+1];
    end
    if (advance && in_valid) begin
      out_index <= in_index;
      out_short <= short_press;
      out_long  <= long_press;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-IDX_W-2){1'b0}}, out_long, out_short, out_index};

  // A result never reports both kinds of press at once.
  `ASSERT_CLK(a_one_event, out_valid |-> !(out_short && out_long), "short and long press together")
  // Buttons outside the active range never touch the stored state.
  `ASSERT_CLK(a_inactive_no_write, (in_valid && !active) |-> !state_wr, "inactive button written")
  // A sample that moves forward always shows up as a result next cycle.
  `ASSERT_CLK(a_advance_result, (in_valid && advance) |=> out_valid, "sample lost in pipeline")
  // Both pipeline registers come out of reset empty.
  `ASSERT_CLK(a_reset_empty, $past(rst) |-> (!out_valid && !in_valid), "pipeline not empty after reset")

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for button_press_hold_classifier.
// Depends on bphc_pkg and the classifier RTL; it needs no other file.
`timescale 1ns / 100ps

module tb_top
  import bphc_pkg::*;
();

  localparam int NUM_BUTTONS = 8;
  // The run is ended by force if it gets this far; a correct run takes a small
  // fraction of it.
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;
  // Index 3 is not mapped to a register; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // One result transaction, split into its fields.
  typedef struct packed {
    logic [IDX_W-1:0] button;
    logic             short_press;
    logic             long_press;
  } press_event_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  button_press_hold_classifier #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Our own copy of the classifier: the three registers and the state of
  // every button, updated at the edge where a sample transaction is accepted.
  logic [CFG_W-1:0] cur_debounce = DEBOUNCE_RESET;
  logic [CFG_W-1:0] cur_hold     = HOLD_RESET;
  logic [CNT_W-1:0] cur_active   = '0;

  logic             btn_level      [NUM_BUTTONS];
  logic [NOW_W-1:0] btn_press_at   [NUM_BUTTONS];
  logic [NOW_W-1:0] btn_release_at [NUM_BUTTONS];
  logic             btn_ignore     [NUM_BUTTONS];
  logic             btn_long       [NUM_BUTTONS];

  // Events still owed by the block, oldest first.
  press_event_t pending_events[$];

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  logic [NOW_W-1:0] clock_ms = '0;

  initial begin
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_level[b]      = 1'b0;
      btn_press_at[b]   = '0;
      btn_release_at[b] = '0;
      btn_ignore[b]     = 1'b0;
      btn_long[b]       = 1'b0;
    end
  end

  // Number of buttons in use; a count above the array size saturates.
  function automatic int active_buttons();
    return (cur_active > NUM_BUTTONS) ? NUM_BUTTONS : int'(cur_active);
  endfunction

  // True when more than lim milliseconds have passed since stamp. The
  // difference wraps at 32 bits, so a timestamp rollover is handled for free.
  function automatic logic time_exceeds(logic [NOW_W-1:0] now, logic [NOW_W-1:0] stamp,
                                        logic [CFG_W-1:0] lim);
    logic [NOW_W-1:0] diff;
    diff = now - stamp;
    return diff > NOW_W'(lim);
  endfunction

  // Classifies one sample and advances that button's state. The rules run in
  // a fixed order and each one sees what the earlier ones wrote.
  function automatic press_event_t classify_sample(logic [IDX_W-1:0] idx, logic lvl,
                                                   logic [NOW_W-1:0] now);
    press_event_t ev;
    logic         was;
    ev = '{button: idx, short_press: 1'b0, long_press: 1'b0};
    if (int'(idx) < active_buttons()) begin
      was = btn_level[idx];
      // Debounced release: note when it happened.
      if (lvl && !was && time_exceeds(now, btn_press_at[idx], cur_debounce))
        btn_release_at[idx] = now;
      // Debounced press: a short press, unless a release after a hold is
      // still being swallowed.
      if (!lvl && was && time_exceeds(now, btn_release_at[idx], cur_debounce)) begin
        if (!btn_ignore[idx]) ev.short_press = 1'b1;
        else btn_ignore[idx] = 1'b0;
        btn_press_at[idx] = now;
      end
      // Held long enough with long mode off: switch it on.
      if (!lvl && !btn_long[idx] && time_exceeds(now, btn_press_at[idx], cur_hold)) begin
        btn_ignore[idx]   = 1'b1;
        btn_press_at[idx] = now;
        btn_long[idx]     = 1'b1;
      end
      // Debounced release again, now deciding on a long press.
      if (lvl && !was && time_exceeds(now, btn_press_at[idx], cur_debounce)) begin
        if (!btn_ignore[idx] && btn_long[idx]) ev.long_press = 1'b1;
        else btn_ignore[idx] = 1'b0;
        btn_release_at[idx] = now;
      end
      // Held long enough with long mode on: switch it off.
      if (!lvl && btn_long[idx] && time_exceeds(now, btn_press_at[idx], cur_hold)) begin
        btn_ignore[idx]   = 1'b1;
        btn_press_at[idx] = now;
        btn_long[idx]     = 1'b0;
      end
      btn_level[idx] = lvl;
    end
    return ev;
  endfunction

  // Receiver side: tready is redrawn at every edge according to the stall
  // rate of the current phase.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker. Every accepted result transaction is compared with the
  // oldest pending event.
  always @(posedge clk) begin
    press_event_t got;
    press_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.button      = m_axis_tdata[2:0];
      got.short_press = m_axis_tdata[3];
      got.long_press  = m_axis_tdata[4];
      if (pending_events.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: button %0d short %0b long %0b",
                   got.button, got.short_press, got.long_press);
      end else begin
        want = pending_events.pop_front();
        if (got != want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: expected btn %0d s %0b l %0b, got btn %0d s %0b l %0b",
                     want.button, want.short_press, want.long_press,
                     got.button, got.short_press, got.long_press);
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sends one sample transaction, with random idle cycles ahead of it. tvalid
  // is left high afterward, so that back-to-back samples never drop it.
  task automatic send_sample(logic [IDX_W-1:0] idx, logic lvl, logic [NOW_W-1:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, now, lvl, idx};
    do @(posedge clk); while (!s_axis_tready);
    pending_events.push_back(classify_sample(idx, lvl, now));
  endtask

  // Stops the sample stream and waits until every pending event has come back,
  // so that the block is idle and registers may be written.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_events.size() != 0);
  endtask

  // One register write transaction. cfg_valid stays high for a following
  // write; cfg_close lowers it after the last one.
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: cur_debounce = data;
      REG_HOLD:     cur_hold     = data;
      REG_ACTIVE:   cur_active   = data[CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
  endtask

  // Writes all three registers; only the low bits of the active count word
  // are meant to matter.
  task automatic apply_settings(logic [CFG_W-1:0] deb, logic [CFG_W-1:0] hold,
                                logic [CFG_W-1:0] active_word);
    cfg_write(REG_DEBOUNCE, deb);
    cfg_write(REG_HOLD, hold);
    cfg_write(REG_ACTIVE, active_word);
    cfg_close();
  endtask

  // Time step between samples, scaled to the thresholds so that bounces,
  // near misses of both thresholds and long waits all show up.
  function automatic logic [NOW_W-1:0] next_gap();
    int unsigned roll;
    longint      g;
    roll = $urandom_range(99);
    if (roll < 30)      g = $urandom_range(0, cur_debounce / 2);
    else if (roll < 55) g = longint'(cur_debounce) - 2 + longint'($urandom_range(0, 4));
    else if (roll < 80) g = longint'(cur_debounce) + 1
                            + longint'($urandom_range(0, cur_debounce + 50));
    else if (roll < 95) g = longint'(cur_hold) - 2 + longint'($urandom_range(0, 4));
    else                g = longint'($urandom);
    if (g < 0) g = 0;
    return g[NOW_W-1:0];
  endfunction

  // Right after reset no button is in use, so every sample comes back empty.
  task automatic test_unused_buttons();
    send_sample(3'd0, 1'b0, 32'h0000_0000);
    send_sample(3'd7, 1'b1, 32'hFFFF_FFFF);
    send_sample(3'd3, 1'b1, 32'hA5A5_A5A5);
    send_sample(3'd4, 1'b0, 32'h5A5A_5A5A);
  endtask

  // The unmapped index is written with all ones and the active count with
  // junk in its upper bits; buttons 0 to 2 are then in use, 3 is not.
  task automatic test_register_map();
    drain();
    cfg_write(REG_UNUSED, 16'hFFFF);
    cfg_write(REG_ACTIVE, 16'hFFF3);
    cfg_close();
    send_sample(3'd3, 1'b1, 32'd200);
    send_sample(3'd2, 1'b1, 32'd200);
  endtask

  // Short press on button 0, with a press edge exactly at the debounce time
  // (rejected) and then one millisecond past it (accepted).
  task automatic test_short_press();
    drain();
    apply_settings(16'd50, 16'd1000, 16'h7008);
    send_sample(3'd0, 1'b1, 32'd100);
    send_sample(3'd0, 1'b0, 32'd150);
    send_sample(3'd0, 1'b1, 32'd160);
    send_sample(3'd0, 1'b0, 32'd211);
    send_sample(3'd0, 1'b1, 32'd262);
  endtask

  // Hold sequence on button 5: a hold at exactly the hold time does nothing,
  // one past it turns long mode on and swallows the release; the next full
  // press then gives a long press, and a second hold turns long mode off.
  task automatic test_long_press();
    send_sample(3'd5, 1'b1, 32'd1000);
    send_sample(3'd5, 1'b0, 32'd2000);
    send_sample(3'd5, 1'b0, 32'd3000);
    send_sample(3'd5, 1'b0, 32'd3001);
    send_sample(3'd5, 1'b1, 32'd3100);
    send_sample(3'd5, 1'b0, 32'd3200);
    send_sample(3'd5, 1'b1, 32'd3300);
    send_sample(3'd5, 1'b0, 32'd3400);
    send_sample(3'd5, 1'b0, 32'd4401);
    send_sample(3'd5, 1'b1, 32'd4500);
  endtask

  // Both thresholds at zero, then both at their maximum with timestamps that
  // wrap past zero.
  task automatic test_threshold_extremes();
    drain();
    apply_settings(16'd0, 16'd0, 16'h0008);
    send_sample(3'd7, 1'b1, 32'd10);
    send_sample(3'd7, 1'b0, 32'd10);
    send_sample(3'd7, 1'b0, 32'd11);
    drain();
    apply_settings(16'hFFFF, 16'hFFFF, 16'h000F);
    send_sample(3'd6, 1'b1, 32'hFFFF_FFF0);
    send_sample(3'd6, 1'b0, 32'h0000_FFF0);
    send_sample(3'd6, 1'b1, 32'h0001_FFEF);
  endtask

  // Random traffic: mostly press and release sequences on one button at a
  // time with random timing, some bouncing levels, and stray samples for
  // buttons that may be out of use. Only samples for buttons in use count.
  task automatic test_random_traffic(int idle, int stall, logic [CFG_W-1:0] deb,
                                     logic [CFG_W-1:0] hold, logic [CFG_W-1:0] active_word,
                                     logic [NOW_W-1:0] base, int n_items);
    int               counted;
    int unsigned      roll;
    logic [IDX_W-1:0] btn;
    logic             lvl;
    logic [7:0]       held_level;
    drain();
    apply_settings(deb, hold, active_word);
    sender_idle_pct = idle;
    recv_stall_pct  = stall;
    clock_ms        = base;
    held_level      = 8'hFF;
    counted         = 0;
    btn             = '0;
    while (counted < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8)
        btn = IDX_W'($urandom_range(NUM_BUTTONS - 1));
      else if (roll < 35 && active_buttons() > 0)
        btn = IDX_W'($urandom_range(active_buttons() - 1));
      roll = $urandom_range(99);
      if (roll < 40) held_level[btn] = ~held_level[btn];
      lvl = (roll >= 85) ? 1'($urandom_range(1)) : held_level[btn];
      clock_ms = clock_ms + next_gap();
      send_sample(btn, lvl, clock_ms);
      if (int'(btn) < active_buttons()) counted++;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_unused_buttons();
    test_register_map();
    test_short_press();
    test_long_press();
    test_threshold_extremes();

    test_random_traffic(0, 0, 16'd50, 16'd1000, 16'h0008, 32'h0000_0000, 100);
    test_random_traffic(62, 0, 16'd0, 16'd0, 16'hA5A5, 32'hFFFF_F000, 100);
    test_random_traffic(0, 62, 16'hFFFF, 16'hFFFF, 16'h5A5F, 32'h8000_0000, 100);
    test_random_traffic(35, 35, 16'($urandom_range(1, 300)), 16'($urandom_range(200, 3000)),
                        {12'($urandom), 4'($urandom_range(3, 15))}, $urandom, 100);

    // Let the last results drain, then keep watching so that any
    // stray result the block still puts out is caught.
    drain();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
